/* sv/sha512_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-512 package
// Shared types, constants and a rotate function for the SHA-512 stream hasher.
// ----------------------------------------------------------------------------
package sha512_pkg;

    localparam int unsigned BLOCK_BYTES   = 128;
    localparam int unsigned LEN_FIELD_POS = 112;
    localparam int unsigned ROUNDS        = 80;
    localparam int unsigned DIGEST_WORDS  = 8;
    localparam logic [7:0]  PAD_BYTE      = 8'h80;

    localparam logic REQ_DATA     = 1'b0;
    localparam logic REQ_FINALIZE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_COMP,
        ST_EMIT
    } state_t;

    typedef logic [63:0] word_t;

    // Handshake from the controller to the compression core.
    typedef struct packed {
        logic start;
    } core_ctl_t;

    localparam word_t INIT_HASH [DIGEST_WORDS] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam word_t ROUND_K [ROUNDS] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic word_t ror64(input word_t x, input int unsigned n);
        ror64 = (x >> n) | (x << (64 - n));
    endfunction

endpackage

/* sv/sha512_core.sv */
// ----------------------------------------------------------------------------
// SHA-512 compression core
// Runs one round per cycle over a 16-word rolling message schedule.
// ----------------------------------------------------------------------------
module sha512_round_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sha512_pkg::core_ctl_t ctl,
    input  logic                  load,
    input  logic [63:0]           load_word,
    input  logic                  init_hash,
    output logic                  busy,
    output logic [63:0]           hash_word0,
    input  logic                  shift_out
);
    import sha512_pkg::*;

    word_t       w_reg [16];
    word_t       v_reg [8];
    word_t       h_reg [8];
    logic [6:0]  round_reg;
    logic        run_reg;
    logic        fold_reg;

    word_t sum0, sum1, maj, ch, t1, t2, s0, s1, w_new;

    always_comb
    begin
        sum1 = ror64(v_reg[4], 14) ^ ror64(v_reg[4], 18) ^ ror64(v_reg[4], 41);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        sum0 = ror64(v_reg[0], 28) ^ ror64(v_reg[0], 34) ^ ror64(v_reg[0], 39);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1   = v_reg[7] + sum1 + ch + ROUND_K[round_reg] + w_reg[0];
        t2   = sum0 + maj;
        s0   = ror64(w_reg[1], 1) ^ ror64(w_reg[1], 8) ^ (w_reg[1] >> 7);
        s1   = ror64(w_reg[14], 19) ^ ror64(w_reg[14], 61) ^ (w_reg[14] >> 6);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
    end

    assign busy       = run_reg | fold_reg;
    assign hash_word0 = h_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            fold_reg  <= 1'b0;
            round_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= INIT_HASH[i];
            end
        end
        else
        begin
            fold_reg <= 1'b0;
            if (init_hash)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= INIT_HASH[i];
                end
            end
            else if (shift_out)
            begin
                for (int i = 0; i < 7; i++)
                begin
                    h_reg[i] <= h_reg[i + 1];
                end
                h_reg[7] <= h_reg[0];
            end
            else if (fold_reg)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
            if (ctl.start)
            begin
                run_reg   <= 1'b1;
                round_reg <= '0;
            end
            else if (run_reg)
            begin
                if (round_reg == 7'(ROUNDS - 1))
                begin
                    run_reg  <= 1'b0;
                    fold_reg <= 1'b1;
                end
                round_reg <= round_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= load_word;
        end
        else if (run_reg)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_new;
        end
        if (ctl.start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (run_reg)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

`ifndef ASSERT_OFF
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |-> !busy) else $error("start while compressing");
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !run_reg) else $error("schedule load during rounds");
    a_fold_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        fold_reg |-> $past(run_reg)) else $error("fold without rounds");
`endif

endmodule

/* sv/sha512_stream_hasher.sv */
// ----------------------------------------------------------------------------
// SHA-512 stream hasher
// Byte-wide SHA-512 with padding and a word-serial digest output.
// ----------------------------------------------------------------------------
// Message bytes are accepted back to back, except the byte that completes a
// 128-byte block: the block is then compressed by one shared round unit doing
// one of the 80 rounds per cycle, and the input is not ready during the 80
// rounds, the fold of the result into the chaining words and the return to
// idle.
// A finalize transfer pads the message (0x80, zeros, 64-bit big-endian bit
// length behind 64 zero bits) one byte at a time, runs one or two compressions,
// and then sends the eight digest words, most significant first, with tlast
// on the eighth. The hasher then starts a new message by itself.
// Bytes are gathered eight at a time into a 64-bit word that is shifted into
// the core's 16-word schedule, so no block memory is needed.
module sha512_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // [63:0] digest_word, [66:64] word_index, zero above
    output logic        m_tlast     // last_word
);
    import sha512_pkg::*;

    state_t      state_reg, state_next;
    logic [6:0]  fill_reg;
    logic [63:0] count_reg;
    logic [63:0] acc_reg;
    logic [2:0]  widx_reg;
    logic        second_reg;   // length block still to come after this one
    logic        ret_reg;      // digest is sent once the last compression is done
    core_ctl_t   ctl;
    logic        core_busy;
    logic [63:0] hash_word0;
    logic        load, init_hash, shift_out;
    logic [63:0] load_word;
    logic        pad_byte_go;
    logic [7:0]  pad_val;
    logic [63:0] bits;

    assign bits = {count_reg[60:0], 3'b000};

    sha512_round_unit u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .load      (load),
        .load_word (load_word),
        .init_hash (init_hash),
        .busy      (core_busy),
        .hash_word0(hash_word0),
        .shift_out (shift_out)
    );

    wire in_fire  = s_tvalid & s_tready;
    wire out_fire = m_tvalid & m_tready;

    // Byte to place in the pad/length phases.
    always_comb
    begin
        if (state_reg == ST_LEN)
        begin
            pad_val = bits[8'(63 - 8 * fill_reg[2:0]) -: 8];
        end
        else
        begin
            pad_val = 8'h00;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // A transfer that fills the block compresses it first, even a
                // finalize whose pad byte lands in the last position.
                if (in_fire && fill_reg == 7'd127)
                begin
                    state_next = ST_COMP;
                end
                else if (in_fire && s_tuser == REQ_FINALIZE)
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (fill_reg == 7'd127)
                begin
                    state_next = ST_COMP;
                end
                else if (fill_reg == 7'(BLOCK_BYTES - 9) && !second_reg)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (fill_reg == 7'd127)
                begin
                    state_next = ST_COMP;
                end
            end
            ST_COMP:
            begin
                if (!ctl.start && !core_busy)
                begin
                    if (second_reg)
                    begin
                        state_next = ST_PAD;
                    end
                    else if (ret_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_fire && widx_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready    = (state_reg == ST_IDLE);
        m_tvalid    = (state_reg == ST_EMIT);
        m_tdata     = {5'b0, widx_reg, hash_word0};
        m_tlast     = (widx_reg == 3'd7);
        shift_out   = out_fire;
        init_hash   = out_fire && widx_reg == 3'd7;
        pad_byte_go = (state_reg == ST_PAD) || (state_reg == ST_LEN);
        load_word   = {acc_reg[55:0], (pad_byte_go ? pad_val : s_tdata)};
        if (in_fire && s_tuser == REQ_FINALIZE)
        begin
            load_word = {acc_reg[55:0], PAD_BYTE};
        end
        load        = ((in_fire || pad_byte_go) && fill_reg[2:0] == 3'd7);
        ctl.start   = (state_reg != ST_COMP) && (state_next == ST_COMP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            count_reg  <= '0;
            widx_reg   <= '0;
            second_reg <= 1'b0;
            ret_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire || pad_byte_go)
            begin
                fill_reg <= fill_reg + 7'd1;
            end
            if (in_fire && s_tuser == REQ_DATA)
            begin
                count_reg <= count_reg + 64'd1;
            end
            if (in_fire && s_tuser == REQ_FINALIZE)
            begin
                ret_reg    <= 1'b1;
                second_reg <= (fill_reg >= 7'(LEN_FIELD_POS));
            end
            if (state_reg == ST_COMP && state_next == ST_PAD)
            begin
                second_reg <= 1'b0;
            end
            if (out_fire)
            begin
                widx_reg <= widx_reg + 3'd1;
            end
            if (init_hash)
            begin
                count_reg <= '0;
                ret_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire || pad_byte_go)
        begin
            acc_reg <= load_word;
        end
    end

`ifndef ASSERT_OFF
    a_emit_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> fill_reg == 7'd0) else $error("emit with partial block");
    a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && m_tlast) |=> (state_reg == ST_IDLE && count_reg == 64'd0))
        else $error("no return to initial state");
    a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        core_busy |-> !s_tready) else $error("ready while compressing");
`endif

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 stream hasher testbench
// Streams messages byte by byte with finalize transfers, predicts each digest
// with a behavioral SHA-512 and checks every output word, with random stalls in most phases.
// ----------------------------------------------------------------------------
module testbench;
    import sha512_pkg::*;

    typedef struct {
        word_t      dword;
        logic [2:0] idx;
        logic       last;
    } digest_beat_t;

    typedef struct {
        logic       fin;
        logic [7:0] byte_val;
        logic       typed;     // expected digest typed in below
        word_t      word0;     // first digest word when typed
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tlast;

    sha512_stream_hasher dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Predictor state: chaining words, the partial block and the length.
    word_t        chain [DIGEST_WORDS];
    logic [7:0]   blk [BLOCK_BYTES];
    int unsigned  fill;
    logic [63:0]  msg_len;
    digest_beat_t digest_q [$];
    int           errors;
    int           idle_cycles;
    int           send_idle_pct;
    int           recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    task automatic compress_blk();
        word_t w [ROUNDS];
        word_t v [DIGEST_WORDS];
        word_t t1;
        word_t t2;
        for (int t = 0; t < 16; t++)
        begin
            w[t] = '0;
            for (int i = 0; i < 8; i++)
                w[t] = (w[t] << 8) | word_t'(blk[t * 8 + i]);
        end
        for (int t = 16; t < ROUNDS; t++)
            w[t] = (rotr(w[t-2], 19) ^ rotr(w[t-2], 61) ^ (w[t-2] >> 6)) + w[t-7]
                 + (rotr(w[t-15], 1) ^ rotr(w[t-15], 8) ^ (w[t-15] >> 7)) + w[t-16];
        for (int i = 0; i < DIGEST_WORDS; i++)
            v[i] = chain[i];
        for (int t = 0; t < ROUNDS; t++)
        begin
            t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
            t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < DIGEST_WORDS; i++)
            chain[i] += v[i];
    endtask

    task automatic restart_hash();
        for (int i = 0; i < DIGEST_WORDS; i++)
            chain[i] = INIT_HASH[i];
        fill    = 0;
        msg_len = '0;
    endtask

    // Applies one accepted transfer to the predictor and queues any digest.
    task automatic predict_digest(input logic fin, input logic [7:0] b);
        logic [63:0] bits;
        int unsigned pos;
        digest_beat_t beat;
        if (fin == REQ_DATA)
        begin
            blk[fill] = b;
            fill      = (fill + 1) % BLOCK_BYTES;
            msg_len   = msg_len + 1;
            if (fill == 0)
                compress_blk();
        end
        else
        begin
            bits = msg_len << 3;
            pos = fill;
            blk[pos] = PAD_BYTE;
            pos++;
            if (pos > LEN_FIELD_POS)
            begin
                while (pos < BLOCK_BYTES)
                begin
                    blk[pos] = 8'h00;
                    pos++;
                end
                compress_blk();
                pos = 0;
            end
            while (pos < BLOCK_BYTES - 8)
            begin
                blk[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++)
                blk[BLOCK_BYTES - 8 + i] = bits[56 - 8 * i +: 8];
            compress_blk();
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                beat.dword = chain[i];
                beat.idx   = 3'(i);
                beat.last  = (i == DIGEST_WORDS - 1);
                digest_q.push_back(beat);
            end
            restart_hash();
        end
    endtask

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Output side: random stalls and a check of every accepted word.
    always @(posedge clk or negedge rst_n)
    begin
        digest_beat_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_tvalid && m_tready)
            begin
                if (digest_q.size() == 0)
                    report_mismatch("unexpected word", m_tdata[63:0], '0);
                else
                begin
                    want = digest_q.pop_front();
                    if (m_tdata[63:0] !== want.dword)
                        report_mismatch("digest_word", m_tdata[63:0], want.dword);
                    if (m_tdata[66:64] !== want.idx)
                        report_mismatch("word_index", word_t'(m_tdata[66:64]),
                                        word_t'(want.idx));
                    if (m_tdata[71:67] !== 5'd0)
                        report_mismatch("tdata pad", word_t'(m_tdata[71:67]), '0);
                    if (m_tlast !== want.last)
                        report_mismatch("tlast", word_t'(m_tlast), word_t'(want.last));
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Sends one transfer, holding it until accepted, with random idle gaps.
    // The valid stays high after acceptance until the next gap or transfer.
    task automatic send_req(input logic fin, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fin;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_digest(fin, b);
    endtask

    task automatic drain_digests();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (digest_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_req(REQ_DATA, 8'($urandom_range(255)));
        send_req(REQ_FINALIZE, 8'($urandom_range(255)));
    endtask

    stim_row_t rows [$];
    stim_row_t r;
    int        sent;
    int        len;
    int        boundary_lens [2] = '{111, 127};

    initial
    begin
        errors        = 0;
        idle_cycles   = 0;
        send_idle_pct = 23;
        recv_idle_pct = 46;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        s_tuser       = REQ_DATA;
        for (int i = 0; i < BLOCK_BYTES; i++)
            blk[i] = 8'h00;
        restart_hash();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: empty message with a data byte riding on the finalize
        // (its digest is well known), "abc", all-ones and zero bytes.
        rows.push_back('{REQ_FINALIZE, 8'hFF, 1'b1, 64'hcf83e1357eefb8bd});
        rows.push_back('{REQ_DATA, 8'h61, 1'b0, '0});
        rows.push_back('{REQ_DATA, 8'h62, 1'b0, '0});
        rows.push_back('{REQ_DATA, 8'h63, 1'b0, '0});
        rows.push_back('{REQ_FINALIZE, 8'h00, 1'b1, 64'hddaf35a193617aba});
        rows.push_back('{REQ_DATA, 8'hFF, 1'b0, '0});
        rows.push_back('{REQ_DATA, 8'h00, 1'b0, '0});
        rows.push_back('{REQ_FINALIZE, 8'h00, 1'b0, '0});
        rows.push_back('{REQ_FINALIZE, 8'hA5, 1'b0, '0});
        foreach (rows[k])
        begin
            r = rows[k];
            send_req(r.fin, r.byte_val);
            if (r.typed && digest_q.size() >= DIGEST_WORDS
                && digest_q[digest_q.size() - DIGEST_WORDS].dword !== r.word0)
                report_mismatch("known digest",
                                digest_q[digest_q.size() - DIGEST_WORDS].dword, r.word0);
        end
        drain_digests();

        // Pad boundary lengths: the longest message padded in one block, and a pad byte
        // that lands in the last position of a block.
        foreach (boundary_lens[k])
            send_message(boundary_lens[k]);
        drain_digests();

        // Random messages, mostly short, in three idling phases.
        sent = 0;
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 46 : 0;
            recv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 23 : 0;
            while (sent < 70 * (ph + 1))
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(140) : $urandom_range(20);
                send_message(len);
                sent += len + 1;
            end
            // Hold the input until every digest has come back.
            drain_digests();
        end

        drain_digests();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

/* files.f */
sv/sha512_pkg.sv
sv/sha512_core.sv
sv/sha512_stream_hasher.sv
test/testbench.sv
